// File: sv/ssp_pkg.sv
// Shared types and constants for the size string parser.
package ssp_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int SIZE_W         = 64;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_M     = 8'h4d;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Y     = 8'h59;

  localparam logic [4:0] SHIFT_NONE = 5'd0;
  localparam logic [4:0] SHIFT_KB   = 5'd10;
  localparam logic [4:0] SHIFT_MB   = 5'd20;
  localparam logic [4:0] SHIFT_GB   = 5'd30;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [SIZE_W-1:0] size_value;
    logic                     bad_suffix;
  } out_t;

  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_SUFFIX = 5'b01000,
    PH_TRAIL  = 5'b10000
  } phase_t;

  typedef enum logic [12:0] {
    SM_EMPTY = 13'b0000000000001,
    SM_B     = 13'b0000000000010,
    SM_BY    = 13'b0000000000100,
    SM_BYT   = 13'b0000000001000,
    SM_BYTE  = 13'b0000000010000,
    SM_BYTES = 13'b0000000100000,
    SM_K     = 13'b0000001000000,
    SM_M     = 13'b0000010000000,
    SM_G     = 13'b0000100000000,
    SM_KB    = 13'b0001000000000,
    SM_MB    = 13'b0010000000000,
    SM_GB    = 13'b0100000000000,
    SM_FAIL  = 13'b1000000000000
  } match_t;

endpackage

// File: sv/size_string_parser.sv
// Size string parser: decimal number, optional unit; one character per unstalled cycle.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | ssp_pkg::in_t  (character, last_char)
//   out_    | output    | out_valid / out_stall | ssp_pkg::out_t (size_value, bad_suffix)
//
// One character is taken per clock while in_stall is low. out_valid rises once the last
// character has passed the finished-string and result registers: parse state, then scale
// and sign. Characters that are not last are absorbed without blocking; in_stall
// rises only when a finished result and the one behind it are both held by out_stall.
// rst_n is synchronous and returns the parse state to the leading whitespace phase.
module size_string_parser #(
  parameter int VALUE_BITS = ssp_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ssp_pkg::out_t out_data
);

  localparam int              VB  = VALUE_BITS;
  localparam int              WB  = VALUE_BITS + 4;
  localparam logic [VB-1:0]   CAP = {1'b1, {(VB-1){1'b0}}};

  // input register
  logic          in_v_r;
  ssp_pkg::in_t  in_r;

  // parse state
  ssp_pkg::phase_t ph_r, ph_nxt;
  ssp_pkg::match_t sm_r, sm_nxt;
  logic            neg_r, neg_nxt;
  logic [VB-1:0]   mag_r, mag_nxt;
  logic            seen_r, seen_nxt;
  logic            ce_r, ce_nxt;

  // finished string
  logic            fin_v_r;
  ssp_pkg::match_t fin_sm_r;
  logic            fin_neg_r;
  logic [VB-1:0]   fin_mag_r;
  logic            fin_seen_r;

  // result register
  logic          out_v_r;
  ssp_pkg::out_t out_r, out_nxt;

  logic out_move, fin_move, st_move, consume, finish;

  assign out_move = !out_v_r || !out_stall;
  assign fin_move = !fin_v_r || out_move;
  assign st_move  = !in_v_r || !in_r.last_char || fin_move;
  assign consume  = in_v_r && st_move;
  assign finish   = consume && in_r.last_char;
  assign in_stall = !st_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (st_move) begin
      in_v_r <= in_valid;
    end
    if (st_move && in_valid) begin
      in_r <= in_data;
    end
  end

  // character decode and next parse state
  logic [7:0]    c, uc;
  logic          digit, trim_ws, lead_ws, sign_ch;
  logic [WB-1:0] wide;

  always_comb begin
    c       = in_r.character;
    uc      = (c >= ssp_pkg::CH_LC_A && c <= ssp_pkg::CH_LC_Z) ? c - ssp_pkg::CH_CASE : c;
    digit   = c >= ssp_pkg::CH_ZERO && c <= ssp_pkg::CH_NINE;
    trim_ws = c == ssp_pkg::CH_SPACE || c == ssp_pkg::CH_TAB ||
              c == ssp_pkg::CH_CR || c == ssp_pkg::CH_LF;
    lead_ws = trim_ws || c == ssp_pkg::CH_VT || c == ssp_pkg::CH_FF;
    sign_ch = c == ssp_pkg::CH_PLUS || c == ssp_pkg::CH_MINUS;
    wide    = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + WB'(c[3:0]);

    ph_nxt   = ph_r;
    sm_nxt   = sm_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    seen_nxt = seen_r;
    ce_nxt   = ce_r || c == ssp_pkg::CH_NUL;

    if (!ce_r && c != ssp_pkg::CH_NUL) begin
      if (digit && (ph_r == ssp_pkg::PH_LEAD || ph_r == ssp_pkg::PH_SIGN ||
                    ph_r == ssp_pkg::PH_DIGITS)) begin
        seen_nxt = 1'b1;
        sm_nxt   = ssp_pkg::SM_EMPTY;
        ph_nxt   = ssp_pkg::PH_DIGITS;
        mag_nxt  = (wide > {4'b0000, CAP}) ? CAP : wide[VB-1:0];
      end else begin
        case (ph_r)
          ssp_pkg::PH_LEAD: begin
            if (sign_ch) begin
              neg_nxt = c == ssp_pkg::CH_MINUS;
              ph_nxt  = ssp_pkg::PH_SIGN;
            end else if (!lead_ws) begin
              ph_nxt = ssp_pkg::PH_SUFFIX;
            end
          end
          ssp_pkg::PH_SIGN, ssp_pkg::PH_DIGITS: ph_nxt = ssp_pkg::PH_SUFFIX;
          default: ;
        endcase
        if (sm_r != ssp_pkg::SM_FAIL) begin
          if (trim_ws) begin
            if (sm_r != ssp_pkg::SM_EMPTY) ph_nxt = ssp_pkg::PH_TRAIL;
          end else if (ph_nxt == ssp_pkg::PH_TRAIL) begin
            sm_nxt = ssp_pkg::SM_FAIL;
          end else begin
            case (sm_r)
              ssp_pkg::SM_EMPTY: begin
                if (uc == ssp_pkg::CH_B)      sm_nxt = ssp_pkg::SM_B;
                else if (uc == ssp_pkg::CH_K) sm_nxt = ssp_pkg::SM_K;
                else if (uc == ssp_pkg::CH_M) sm_nxt = ssp_pkg::SM_M;
                else if (uc == ssp_pkg::CH_G) sm_nxt = ssp_pkg::SM_G;
                else                          sm_nxt = ssp_pkg::SM_FAIL;
              end
              ssp_pkg::SM_B:
                sm_nxt = (uc == ssp_pkg::CH_Y) ? ssp_pkg::SM_BY : ssp_pkg::SM_FAIL;
              ssp_pkg::SM_BY:
                sm_nxt = (uc == ssp_pkg::CH_T) ? ssp_pkg::SM_BYT : ssp_pkg::SM_FAIL;
              ssp_pkg::SM_BYT:
                sm_nxt = (uc == ssp_pkg::CH_E) ? ssp_pkg::SM_BYTE : ssp_pkg::SM_FAIL;
              ssp_pkg::SM_BYTE:
                sm_nxt = (uc == ssp_pkg::CH_S) ? ssp_pkg::SM_BYTES : ssp_pkg::SM_FAIL;
              ssp_pkg::SM_K:
                sm_nxt = (uc == ssp_pkg::CH_B) ? ssp_pkg::SM_KB : ssp_pkg::SM_FAIL;
              ssp_pkg::SM_M:
                sm_nxt = (uc == ssp_pkg::CH_B) ? ssp_pkg::SM_MB : ssp_pkg::SM_FAIL;
              ssp_pkg::SM_G:
                sm_nxt = (uc == ssp_pkg::CH_B) ? ssp_pkg::SM_GB : ssp_pkg::SM_FAIL;
              default: sm_nxt = ssp_pkg::SM_FAIL;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      ph_r   <= ssp_pkg::PH_LEAD;
      sm_r   <= ssp_pkg::SM_EMPTY;
      neg_r  <= 1'b0;
      mag_r  <= '0;
      seen_r <= 1'b0;
      ce_r   <= 1'b0;
    end else if (consume) begin
      ph_r   <= ph_nxt;
      sm_r   <= sm_nxt;
      neg_r  <= neg_nxt;
      mag_r  <= mag_nxt;
      seen_r <= seen_nxt;
      ce_r   <= ce_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (fin_move) begin
      fin_v_r <= finish;
    end
    if (fin_move && finish) begin
      fin_sm_r   <= sm_nxt;
      fin_neg_r  <= neg_nxt;
      fin_mag_r  <= mag_nxt;
      fin_seen_r <= seen_nxt;
    end
  end

  // unit scaling with saturation, then sign
  logic [4:0]           shamt;
  logic                 bad;
  logic [VB-1:0]        lim, val, mag_s;
  logic signed [VB-1:0] res;

  always_comb begin
    bad = 1'b0;
    case (fin_sm_r)
      ssp_pkg::SM_EMPTY, ssp_pkg::SM_B, ssp_pkg::SM_BYTE, ssp_pkg::SM_BYTES:
        shamt = ssp_pkg::SHIFT_NONE;
      ssp_pkg::SM_KB: shamt = ssp_pkg::SHIFT_KB;
      ssp_pkg::SM_MB: shamt = ssp_pkg::SHIFT_MB;
      ssp_pkg::SM_GB: shamt = ssp_pkg::SHIFT_GB;
      default: begin
        shamt = ssp_pkg::SHIFT_NONE;
        bad   = 1'b1;
      end
    endcase
    lim   = fin_neg_r ? CAP : CAP - VB'(1);
    val   = fin_seen_r ? fin_mag_r : '0;
    mag_s = (val > (lim >> shamt)) ? lim : (val << shamt);
    res   = fin_neg_r ? -mag_s : mag_s;
    out_nxt.bad_suffix = bad;
    out_nxt.size_value = bad ? '1 : ssp_pkg::SIZE_W'(res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_move) begin
      out_v_r <= fin_v_r;
    end
    if (out_move && fin_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: sv/ssp_checker.sv
// Port-level checks for the size string parser, bound to the top level.
module ssp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input ssp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input ssp_pkg::out_t out_data
);

  // a held input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transaction changed while stalled");

  // a held result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  // an unknown unit always reports minus one
  a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_suffix |-> out_data.size_value == '1)
    else $error("bad suffix without all-ones value");

  // input back-pressure only arises behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no result held");

  // no result comes out straight after leaving reset
  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid ##1 !out_valid)
    else $error("result appeared straight after reset");

endmodule

bind size_string_parser ssp_checker u_ssp_checker (.*);
